// ----- rtl/kocu_pkg.sv -----
// Package for the keyword occurrence counter: widths, keyword tables,
// the token close event type and small helper functions.
// No dependencies.
`timescale 1ns / 1ps

package kocu_pkg;

  // number of keywords and longest keyword in bytes
  localparam int unsigned NumKeys   = 5;
  localparam int unsigned KeyMaxLen = 5;

  // token position counter saturates at its all-ones value
  localparam int unsigned PosBits = 3;

  // width of the internal keyword counters
  localparam int unsigned COUNT_BITS = 16;

  // width of one count on the result stream
  localparam int unsigned OutBits = 16;

  // stream widths
  localparam int unsigned InDataBits  = 8;
  localparam int unsigned OutDataBits = NumKeys * OutBits;

  typedef logic [7:0]            byte_t;
  typedef logic [PosBits-1:0]    pos_t;
  typedef logic [NumKeys-1:0]    key_mask_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OutBits-1:0]    out_count_t;

  localparam pos_t   PosMax   = {PosBits{1'b1}};
  localparam count_t CountMax = {COUNT_BITS{1'b1}};
  localparam out_count_t OutMax = {OutBits{1'b1}};

  // separator characters
  localparam byte_t ChSpace = 8'h20;
  localparam byte_t ChComma = 8'h2C;
  localparam byte_t ChDot   = 8'h2E;
  localparam byte_t ChQuote = 8'h27;
  localparam byte_t ChNul   = 8'h00;

  // keyword spelling, unused tail bytes are zero:
  // hello, men, go, and, with
  localparam byte_t KeyText [NumKeys][KeyMaxLen] = '{
    '{8'h68, 8'h65, 8'h6C, 8'h6C, 8'h6F},
    '{8'h6D, 8'h65, 8'h6E, 8'h00, 8'h00},
    '{8'h67, 8'h6F, 8'h00, 8'h00, 8'h00},
    '{8'h61, 8'h6E, 8'h64, 8'h00, 8'h00},
    '{8'h77, 8'h69, 8'h74, 8'h68, 8'h00}
  };

  localparam pos_t KeyLen [NumKeys] = '{3'd5, 3'd3, 3'd2, 3'd3, 3'd4};

  // token close event from the matcher to the counter bank
  typedef struct packed {
    logic      valid;  // an item was processed this cycle
    logic      last;   // that item ended the text
    key_mask_t hit;    // keywords matched by the token closed this cycle
  } kocu_event_t;

  // true for a byte that splits tokens
  function automatic logic is_separator(byte_t b);
    return (b == ChSpace) || (b == ChComma) || (b == ChDot) || (b == ChQuote);
  endfunction

  // clamp a count to the result field width
  function automatic out_count_t clamp_count(count_t c);
    logic [31:0] wide;
    wide = 32'(c);
    return (wide > 32'(OutMax)) ? OutMax : wide[OutBits-1:0];
  endfunction

endpackage

// ----- rtl/kocu_match.sv -----
// Token matcher: tracks the open token, the keywords it still matches
// and the stopped string flag; emits a close event per processed byte.
// Depends on kocu_pkg.
`timescale 1ns / 1ps

module kocu_match (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  kocu_pkg::byte_t       byte_i,
  input  logic                  last_i,
  output kocu_pkg::kocu_event_t ev_o
);

  kocu_pkg::key_mask_t cand_q, cand_d, cand_post, use_cand, hit;
  kocu_pkg::pos_t      pos_q, pos_d, pos_post, use_pos, key_idx;
  logic                stopped_q, stopped_d;
  logic                is_zero, is_sep, sep_close, tok, fire;

  // byte classification
  assign is_zero   = (byte_i == kocu_pkg::ChNul);
  assign is_sep    = kocu_pkg::is_separator(byte_i);
  assign sep_close = !stopped_q && (is_zero || is_sep);
  assign tok       = !stopped_q && !is_zero && !is_sep;
  assign fire      = sep_close || last_i;

  // candidate filter for a token byte
  assign key_idx = (pos_q < kocu_pkg::pos_t'(kocu_pkg::KeyMaxLen)) ? pos_q : '0;
  always_comb begin
    for (int i = 0; i < kocu_pkg::NumKeys; i++) begin
      cand_post[i] = cand_q[i] && (pos_q < kocu_pkg::KeyLen[i]) &&
                     (kocu_pkg::KeyText[i][key_idx] == byte_i);
    end
  end
  assign pos_post = (pos_q == kocu_pkg::PosMax) ? pos_q : pos_q + 3'd1;

  // a separator closes the token as it was; end of text closes it after the byte
  assign use_cand = tok ? cand_post : cand_q;
  assign use_pos  = tok ? pos_post : pos_q;

  always_comb begin
    for (int i = 0; i < kocu_pkg::NumKeys; i++) begin
      hit[i] = fire && (use_pos != '0) && use_cand[i] &&
               (use_pos == kocu_pkg::KeyLen[i]);
    end
  end

  assign ev_o.valid = adv_i;
  assign ev_o.last  = last_i;
  assign ev_o.hit   = hit;

  // next token state
  always_comb begin
    cand_d    = cand_q;
    pos_d     = pos_q;
    stopped_d = stopped_q;
    if (adv_i) begin
      priority if (last_i) begin
        cand_d    = '1;
        pos_d     = '0;
        stopped_d = 1'b0;
      end else if (sep_close) begin
        cand_d    = '1;
        pos_d     = '0;
        stopped_d = stopped_q | is_zero;
      end else if (tok) begin
        cand_d = cand_post;
        pos_d  = pos_post;
      end else begin
        // stopped string, byte ignored
        stopped_d = stopped_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q    <= '1;
      pos_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      cand_q    <= cand_d;
      pos_q     <= pos_d;
      stopped_q <= stopped_d;
    end
  end

  // end of text leaves a fresh token state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last_i |=> (pos_q == '0) && (cand_q == '1) && !stopped_q)
    else $error("token state not cleared after end of text");

  // an empty token has every keyword still possible
  a_empty_all_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (cand_q == '1))
    else $error("empty token with dropped candidates");

  // a stopped string has no open token
  a_stopped_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (pos_q == '0))
    else $error("open token after string stopped");

endmodule

// ----- rtl/kocu_count.sv -----
// Counter bank and result register: saturating per-keyword counts,
// loaded into the output register at end of text and then cleared.
// Depends on kocu_pkg.
`timescale 1ns / 1ps

module kocu_count (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kocu_pkg::kocu_event_t                ev_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [kocu_pkg::OutDataBits-1:0]     out_data_o
);

  kocu_pkg::count_t counts_q [kocu_pkg::NumKeys];
  kocu_pkg::count_t counts_d [kocu_pkg::NumKeys];
  kocu_pkg::count_t counts_new [kocu_pkg::NumKeys];
  logic [kocu_pkg::OutDataBits-1:0] data_q, data_d;
  logic out_valid_q, out_valid_d;

  // saturating increment with this cycle's hits
  always_comb begin
    for (int i = 0; i < kocu_pkg::NumKeys; i++) begin
      counts_new[i] = (ev_i.hit[i] && (counts_q[i] != kocu_pkg::CountMax)) ?
                      counts_q[i] + 1'b1 : counts_q[i];
      counts_d[i]   = counts_q[i];
      if (ev_i.valid) begin
        counts_d[i] = ev_i.last ? '0 : counts_new[i];
      end
    end
  end

  // result packing, first keyword in the low bits
  always_comb begin
    for (int i = 0; i < kocu_pkg::NumKeys; i++) begin
      data_d[i*kocu_pkg::OutBits +: kocu_pkg::OutBits] =
        kocu_pkg::clamp_count(counts_new[i]);
    end
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (ev_i.valid && ev_i.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < kocu_pkg::NumKeys; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      for (int i = 0; i < kocu_pkg::NumKeys; i++) begin
        counts_q[i] <= counts_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_i.valid && ev_i.last) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = data_q;

  // a result always follows an end of text
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_i.valid && ev_i.last |=> out_valid_q)
    else $error("no result after end of text");

  // counts restart from zero after a result
  a_counts_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_i.valid && ev_i.last |=> (counts_q[0] == '0) && (counts_q[4] == '0))
    else $error("counts not cleared after end of text");

endmodule

// ----- rtl/keyword_occurrence_counter_unit.sv -----
// Top level of the keyword occurrence counter: input register, token
// matcher and counter bank with result register.
// Depends on kocu_pkg, kocu_match and kocu_count.
//
// Usage:
//   Text enters on the slave stream, one byte per transfer in tdata, with
//   tlast set on the final byte of a text. Space, comma, period and
//   apostrophe split tokens; a zero byte ends the string and later bytes up
//   to tlast are ignored. On the tlast byte one result leaves on the master
//   stream: five 16-bit counts for hello, men, go, and, with, low to high.
//   A byte is registered on acceptance and processed as it leaves the input
//   register; the result register is loaded as the tlast byte is processed.
//   Throughput: one byte per cycle unless a held result stalls a tlast byte;
//   match and count update lie between the input and result registers.
//   Reset clears the token state, all counts and both valid flags.
//   When the receiver stalls, the held result blocks only the next tlast
//   byte; ordinary bytes keep flowing until it waits in the input register.
`timescale 1ns / 1ps

module keyword_occurrence_counter_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave stream: tdata[7:0] text_byte, tlast end_of_text
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [kocu_pkg::InDataBits-1:0]       s_axis_tdata_i,
  input  logic                                  s_axis_tlast_i,
  // master stream: tdata count_hello, count_men, count_go, count_and,
  // count_with, 16 bits each from bit 0 up
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [kocu_pkg::OutDataBits-1:0]      m_axis_tdata_o
);

  logic                  in_valid_q, in_valid_d;
  kocu_pkg::byte_t       byte_q;
  logic                  last_q;
  logic                  s_fire, adv, out_valid;
  kocu_pkg::kocu_event_t ev;

  // the registered item advances unless it would overwrite a waiting result
  assign adv             = in_valid_q && (!last_q || !out_valid || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = s_fire || (in_valid_q && !adv);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      byte_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  kocu_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (byte_q),
    .last_i (last_q),
    .ev_o   (ev)
  );

  kocu_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (ev),
    .out_valid_o (out_valid),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = out_valid;

  // a registered item is never dropped while stalled
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(byte_q) && $stable(last_q))
    else $error("stalled input item lost");

endmodule
